// ----- hdl/ffca_pkg.sv -----
// ffca_pkg: shared constants, header layout and controller states for the
// first-fit chunk allocator
// no dependencies
package ffca_pkg;

  localparam int HEAP_UNITS = 4096;
  localparam int UNIT_BYTES = 16;

  localparam int ADDR_W     = $clog2(HEAP_UNITS);       // header memory index
  localparam int UNIT_W     = $clog2(HEAP_UNITS) + 1;   // holds 0..HEAP_UNITS
  localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
  localparam int BYTES_W    = 16;
  localparam int OFF_W      = 16;
  localparam int LIMIT_W    = 13;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic ST_DONE = 1'b0;
  localparam logic ST_OOM  = 1'b1;

  typedef struct packed {
    logic [UNIT_W-1:0] size;
    logic              used;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_START,
    S_A_CHK,
    S_A_APPEND,
    S_A_GRANT,
    S_F_SEEK,
    S_F_WALK,
    S_F_HEAD,
    S_F_MERGE,
    S_F_CLOSE
  } state_t;

endpackage

// ----- hdl/ffca_ram.sv -----
// ffca_ram: generic single-write, single-read synchronous ram with registered
// read data
// no dependencies
module ffca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/first_fit_chunk_allocator_unit.sv -----
// first_fit_chunk_allocator_unit: first-fit allocator over an implicit chunk
// list kept in a header ram
// depends on ffca_pkg and ffca_ram
//
//   channel  | ports                                         | handshake
//   ---------+-----------------------------------------------+-------------------
//   request  | in_req_type, in_request_bytes, in_free_offset | start & !busy
//   result   | out_payload_offset, out_status                | out_valid, 1 cycle
//   config   | cfg_wr_data (heap limit in units)             | cfg_wr_en
//
// one request at a time; the header ram (one read, one write port, registered read
// data) sets the pace; the result strobe follows the last busy cycle
// allocate: start, examine chunk headers in list order, then grant or append
// free: seek and walk over each chunk before the target, read the target header,
// merge each following free chunk header, then close
// a free with a misaligned or zero-page offset answers the cycle after accept
// synchronous active-low reset clears the heap top, the limit (to 4096) and
// control; header entries are never read before they are written
// the receiver cannot stall: out_valid is a one-cycle strobe
module first_fit_chunk_allocator_unit
  import ffca_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic [BYTES_W-1:0] in_request_bytes,
  input  logic [OFF_W-1:0]   in_free_offset,
  output logic               out_valid,
  output logic [OFF_W-1:0]   out_payload_offset,
  output logic               out_status,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data
);

  // control and datapath registers
  state_t              state_r, state_nxt;
  logic [UNIT_W-1:0]   top_r, top_nxt;       // heap top in units
  logic [LIMIT_W-1:0]  limit_r;
  logic [UNIT_W-1:0]   need_r, need_nxt;     // units wanted incl. header
  logic [UNIT_W-1:0]   u_r, u_nxt;           // current chunk start
  logic [UNIT_W-1:0]   sz_r, sz_nxt;         // size to grant
  logic [UNIT_W-1:0]   nx_r, nx_nxt;         // end of merged free run
  logic [ADDR_W-1:0]   tgt_r, tgt_nxt;       // header unit of the freed chunk
  logic [OFF_W-1:0]    off_r, off_nxt;       // echoed free offset
  logic                out_valid_r, out_valid_nxt;
  logic [OFF_W-1:0]    out_off_r, out_off_nxt;
  logic                out_status_r, out_status_nxt;

  // header ram
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  hdr_t                ram_wdata, rd;

  ffca_ram #(
    .WIDTH (HDR_W),
    .DEPTH (HEAP_UNITS)
  ) u_hdr_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (rd)
  );

  // shared conditions
  logic                accept;
  logic [UNIT_W-1:0]   eff_limit;
  logic [UNIT_W-1:0]   need_calc;
  logic                free_ok;
  logic [UNIT_W:0]     sum_u;        // u + size of header just read
  logic [UNIT_W:0]     sum_nx;       // run end + size of header just read
  logic                fit, split, walk_on;
  logic                append_ok;
  logic                u_lt_top, u_lt_tgt, u_eq_tgt;
  logic                merge_ok;
  logic [UNIT_W:0]     grant_u1, append_u1;

  assign accept    = start && !busy;
  assign eff_limit = (limit_r > LIMIT_W'(HEAP_UNITS)) ? UNIT_W'(HEAP_UNITS)
                                                      : UNIT_W'(limit_r);
  // header unit plus payload rounded up to whole units
  assign need_calc = UNIT_W'(({1'b0, in_request_bytes} + (BYTES_W+1)'(UNIT_BYTES - 1))
                             >> UNIT_SHIFT) + UNIT_W'(1);
  assign free_ok   = (in_free_offset[UNIT_SHIFT-1:0] == '0) &&
                     (in_free_offset[OFF_W-1:UNIT_SHIFT] != '0);

  assign sum_u     = {1'b0, u_r} + {1'b0, rd.size};
  assign sum_nx    = {1'b0, nx_r} + {1'b0, rd.size};
  assign fit       = !rd.used && (rd.size >= need_r);
  assign split     = rd.size > need_r;
  assign walk_on   = (rd.size != '0) && (sum_u < {1'b0, top_r});
  assign append_ok = ({1'b0, top_r} + {1'b0, need_r}) <= {1'b0, eff_limit};
  assign u_lt_top  = u_r < top_r;
  assign u_lt_tgt  = u_r < {1'b0, tgt_r};
  assign u_eq_tgt  = u_r == {1'b0, tgt_r};
  assign merge_ok  = !rd.used && (rd.size != '0);
  assign grant_u1  = {1'b0, u_r} + (UNIT_W+1)'(1);
  assign append_u1 = {1'b0, top_r} + (UNIT_W+1)'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_ALLOC) begin
            state_nxt = S_A_START;
          end else if (free_ok) begin
            state_nxt = S_F_SEEK;
          end
        end
      end
      S_A_START: begin
        state_nxt = (top_r != '0) ? S_A_CHK : S_A_APPEND;
      end
      S_A_CHK: begin
        if (fit) begin
          state_nxt = S_A_GRANT;
        end else if (!walk_on) begin
          state_nxt = S_A_APPEND;
        end
      end
      S_A_APPEND: state_nxt = S_IDLE;
      S_A_GRANT:  state_nxt = S_IDLE;
      S_F_SEEK: begin
        if (u_lt_top && u_lt_tgt) begin
          state_nxt = S_F_WALK;
        end else if (u_lt_top && u_eq_tgt) begin
          state_nxt = S_F_HEAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_F_WALK: begin
        state_nxt = walk_on ? S_F_SEEK : S_IDLE;
      end
      S_F_HEAD: begin
        state_nxt = (sum_u < {1'b0, top_r}) ? S_F_MERGE : S_F_CLOSE;
      end
      S_F_MERGE: begin
        if (!merge_ok || (sum_nx >= {1'b0, top_r})) begin
          state_nxt = S_F_CLOSE;
        end
      end
      S_F_CLOSE: state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath, ram control and result
  always_comb begin
    top_nxt        = top_r;
    need_nxt       = need_r;
    u_nxt          = u_r;
    sz_nxt         = sz_r;
    nx_nxt         = nx_r;
    tgt_nxt        = tgt_r;
    off_nxt        = off_r;
    out_valid_nxt  = 1'b0;
    out_off_nxt    = out_off_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = u_r[ADDR_W-1:0];
    ram_wdata      = '{size: sz_r, used: 1'b1};
    ram_re         = 1'b0;
    ram_raddr      = u_r[ADDR_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          need_nxt = need_calc;
          u_nxt    = '0;
          off_nxt  = in_free_offset;
          tgt_nxt  = ADDR_W'(in_free_offset[OFF_W-1:UNIT_SHIFT] - 1'b1);
          if (in_req_type == REQ_FREE && !free_ok) begin
            // bad offset: echo it, nothing changes
            out_valid_nxt  = 1'b1;
            out_off_nxt    = in_free_offset;
            out_status_nxt = ST_DONE;
          end
        end
      end
      S_A_START: begin
        ram_re    = top_r != '0;
        ram_raddr = '0;
      end
      S_A_CHK: begin
        if (fit) begin
          // on a fit, carve any tail off as a new free chunk
          if (split) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(u_r + need_r);
            ram_wdata = '{size: rd.size - need_r, used: 1'b0};
            sz_nxt    = need_r;
          end else begin
            sz_nxt    = rd.size;
          end
        end else if (walk_on) begin
          u_nxt     = sum_u[UNIT_W-1:0];
          ram_re    = 1'b1;
          ram_raddr = sum_u[ADDR_W-1:0];
        end
      end
      S_A_APPEND: begin
        out_valid_nxt = 1'b1;
        if (append_ok) begin
          ram_we         = 1'b1;
          ram_waddr      = top_r[ADDR_W-1:0];
          ram_wdata      = '{size: need_r, used: 1'b1};
          top_nxt        = top_r + need_r;
          out_off_nxt    = OFF_W'({append_u1, {UNIT_SHIFT{1'b0}}});
          out_status_nxt = ST_DONE;
        end else begin
          out_off_nxt    = '0;
          out_status_nxt = ST_OOM;
        end
      end
      S_A_GRANT: begin
        ram_we         = 1'b1;
        out_valid_nxt  = 1'b1;
        out_off_nxt    = OFF_W'({grant_u1, {UNIT_SHIFT{1'b0}}});
        out_status_nxt = ST_DONE;
      end
      S_F_SEEK: begin
        if (u_lt_top && (u_lt_tgt || u_eq_tgt)) begin
          ram_re = 1'b1;
        end else begin
          // offset is not a chunk start below the top
          out_valid_nxt  = 1'b1;
          out_off_nxt    = off_r;
          out_status_nxt = ST_DONE;
        end
      end
      S_F_WALK: begin
        if (walk_on) begin
          u_nxt = sum_u[UNIT_W-1:0];
        end else begin
          out_valid_nxt  = 1'b1;
          out_off_nxt    = off_r;
          out_status_nxt = ST_DONE;
        end
      end
      S_F_HEAD: begin
        nx_nxt    = sum_u[UNIT_W-1:0];
        ram_re    = sum_u < {1'b0, top_r};
        ram_raddr = sum_u[ADDR_W-1:0];
      end
      S_F_MERGE: begin
        // absorb the following free chunk and look at the next one
        if (merge_ok) begin
          nx_nxt    = sum_nx[UNIT_W-1:0];
          ram_re    = sum_nx < {1'b0, top_r};
          ram_raddr = sum_nx[ADDR_W-1:0];
        end
      end
      S_F_CLOSE: begin
        ram_we         = 1'b1;
        ram_wdata      = '{size: nx_r - u_r, used: 1'b0};
        out_valid_nxt  = 1'b1;
        out_off_nxt    = off_r;
        out_status_nxt = ST_DONE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      limit_r     <= LIMIT_W'(HEAP_UNITS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    need_r       <= need_nxt;
    u_r          <= u_nxt;
    sz_r         <= sz_nxt;
    nx_r         <= nx_nxt;
    tgt_r        <= tgt_nxt;
    off_r        <= off_nxt;
    out_off_r    <= out_off_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy               = state_r != S_IDLE;
  assign out_valid          = out_valid_r;
  assign out_payload_offset = out_off_r;
  assign out_status         = out_status_r;

endmodule
